### rtl/fstv_pkg.sv
// Shared types, constants and decode helpers for the four-state string converter.
`timescale 1ns / 1ps

package fstv_pkg;

    localparam int MAX_BITS_DEF = 128;   // default store depth in characters
    localparam int WORD_BITS    = 32;
    localparam int MAX_WORDS    = 4;
    localparam int STORE_BITS   = WORD_BITS * MAX_WORDS;
    localparam int ADDR_BITS    = 3;

    // register indexes (byte address bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_BINARY = 1'b1;

    // trace characters
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_U_LO  = 8'h75;
    localparam logic [7:0] CH_U_UP  = 8'h55;
    localparam logic [7:0] CH_Z_LO  = 8'h7a;
    localparam logic [7:0] CH_Z_UP  = 8'h5a;
    localparam logic [7:0] CH_QUERY = 8'h3f;

    localparam logic [7:0] FOUR_NARROW_LIMIT = 8'd33;  // four-state narrow below this

    // result state codes
    localparam logic [2:0] ST_ZERO        = 3'd0;
    localparam logic [2:0] ST_ONE         = 3'd1;
    localparam logic [2:0] ST_UNKNOWN     = 3'd2;
    localparam logic [2:0] ST_HIGHZ       = 3'd3;
    localparam logic [2:0] ST_BIN_NARROW  = 3'd4;
    localparam logic [2:0] ST_BIN_WIDE    = 3'd5;
    localparam logic [2:0] ST_FOUR_NARROW = 3'd6;
    localparam logic [2:0] ST_FOUR_WIDE   = 3'd7;

    typedef struct packed {
        logic [7:0] width;       // saturated to 1..MAX_BITS
        logic       binary_wide;
    } t_cfg;

    typedef struct packed {
        logic [2:0]                         st;
        logic [1:0]                         last_idx;
        logic                               all_high;
        logic                               bad;
        logic [62:0]                        stamp;
        logic                               skip;
        logic [MAX_WORDS-1:0][WORD_BITS-1:0] value;
        logic [MAX_WORDS-1:0][WORD_BITS-1:0] mask;
    } t_job;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic [2:0] st;
        logic       bad;
    } t_scalar;

    function automatic t_scalar decode_scalar(input logic [7:0] c);
        t_scalar r;
        r.bad = 1'b0;
        unique case (c) inside
            CH_0:                                      r.st = ST_ZERO;
            CH_1:                                      r.st = ST_ONE;
            CH_QUERY, CH_X_LO, CH_X_UP, CH_U_LO, CH_U_UP: r.st = ST_UNKNOWN;
            CH_Z_LO, CH_Z_UP:                          r.st = ST_HIGHZ;
            default: begin
                r.st  = ST_UNKNOWN;
                r.bad = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/fstv_if.sv
// Character input and word output channel interfaces.
`timescale 1ns / 1ps

interface fstv_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;
    logic [62:0] sample_time;
    logic        skip_compare;

    modport source (output valid, char_code, sample_time, skip_compare, input ready);
    modport sink   (input valid, char_code, sample_time, skip_compare, output ready);
endinterface

interface fstv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  state_code;
    logic [31:0] value_word;
    logic [31:0] mask_word;
    logic [1:0]  word_index;
    logic        last_word;
    logic        all_high;
    logic        bad_char;
    logic [62:0] out_time;
    logic        out_skip_compare;

    modport source (output valid, state_code, value_word, mask_word, word_index, last_word,
                    all_high, bad_char, out_time, out_skip_compare, input ready);
    modport sink   (input valid, state_code, value_word, mask_word, word_index, last_word,
                    all_high, bad_char, out_time, out_skip_compare, output ready);
endinterface

### rtl/fstv_front.sv
// Front end: takes characters, accumulates codes and shift stores, classes the signal.
`timescale 1ns / 1ps

module fstv_front #(
    parameter int MAX_BITS = fstv_pkg::MAX_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fstv_in_if.sink         i_char,
    input  fstv_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output fstv_pkg::t_job  o_job
);

    logic [7:0]          r_or, r_and, r_count;
    logic [MAX_BITS-1:0] r_val, r_msk;
    logic [62:0]         r_time;
    logic                r_skip;

    logic [7:0]          c, or_nx, and_nx, count_nx, w_m1;
    logic [MAX_BITS-1:0] val_nx, msk_nx;
    logic                first, scalar, final_char, accept, vbit, mbit;
    fstv_pkg::t_scalar   dec;

    assign c          = i_char.char_code;
    assign first      = (r_count == 8'd0);
    assign scalar     = (i_cfg.width < 8'd2);
    assign count_nx   = r_count + 8'd1;
    assign final_char = scalar || (count_nx >= i_cfg.width);
    // stall only a final character that has nowhere to go
    assign i_char.ready = !(final_char && i_q_full);
    assign accept     = i_char.valid && i_char.ready;
    assign o_push     = accept && final_char;

    assign or_nx  = r_or | c;
    assign and_nx = r_and & c;
    assign vbit   = (c == fstv_pkg::CH_1) || (c == fstv_pkg::CH_Z_LO) ||
                    (c == fstv_pkg::CH_Z_UP);
    assign mbit   = ((c | 8'h01) != fstv_pkg::CH_1);
    assign val_nx = {r_val[MAX_BITS-2:0], vbit};
    assign msk_nx = {r_msk[MAX_BITS-2:0], mbit};
    assign w_m1   = i_cfg.width - 8'd1;
    assign dec    = fstv_pkg::decode_scalar(c);

    always_comb begin
        o_job          = '0;
        o_job.stamp    = first ? i_char.sample_time : r_time;
        o_job.skip     = first ? i_char.skip_compare : r_skip;
        o_job.value    = fstv_pkg::STORE_BITS'(val_nx);
        o_job.mask     = fstv_pkg::STORE_BITS'(msk_nx);
        if (scalar) begin
            o_job.st  = dec.st;
            o_job.bad = dec.bad;
        end else begin
            unique case (or_nx) inside
                fstv_pkg::CH_0: o_job.st = fstv_pkg::ST_ZERO;
                fstv_pkg::CH_1: begin
                    o_job.all_high = (and_nx == fstv_pkg::CH_1);
                    if (i_cfg.binary_wide) begin
                        o_job.st       = fstv_pkg::ST_BIN_WIDE;
                        o_job.last_idx = w_m1[6:5];
                    end else begin
                        o_job.st       = fstv_pkg::ST_BIN_NARROW;
                    end
                end
                fstv_pkg::CH_Z_LO, fstv_pkg::CH_Z_UP: o_job.st = fstv_pkg::ST_HIGHZ;
                fstv_pkg::CH_U_LO, fstv_pkg::CH_U_UP: o_job.st = fstv_pkg::ST_UNKNOWN;
                default: begin
                    if (i_cfg.width < fstv_pkg::FOUR_NARROW_LIMIT) begin
                        o_job.st       = fstv_pkg::ST_FOUR_NARROW;
                    end else begin
                        o_job.st       = fstv_pkg::ST_FOUR_WIDE;
                        o_job.last_idx = w_m1[6:5];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_or    <= 8'h00;
            r_and   <= 8'hff;
            r_count <= 8'd0;
            r_val   <= '0;
            r_msk   <= '0;
            r_time  <= '0;
            r_skip  <= 1'b0;
        end else if (accept) begin
            if (first) begin
                r_time <= i_char.sample_time;
                r_skip <= i_char.skip_compare;
            end
            if (final_char) begin
                r_or    <= 8'h00;
                r_and   <= 8'hff;
                r_count <= 8'd0;
                r_val   <= '0;
                r_msk   <= '0;
            end else begin
                r_or    <= or_nx;
                r_and   <= and_nx;
                r_count <= count_nx;
                r_val   <= val_nx;
                r_msk   <= msk_nx;
            end
        end
    end

endmodule

### rtl/fstv_queue.sv
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps

module fstv_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fstv_pkg::t_job    i_job,
    input  logic              i_pop,
    output fstv_pkg::t_job    o_head,
    output fstv_pkg::t_q_stat o_stat
);

    fstv_pkg::t_job r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_count;
    logic           do_push, do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.count = r_count;
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### rtl/fstv_back.sv
// Back end: drains queued jobs to the output register one word per cycle if ready.
`timescale 1ns / 1ps

module fstv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fstv_pkg::t_job i_head,
    input  logic           i_q_empty,
    output logic           o_pop,
    fstv_out_if.source     o_word
);

    logic        r_valid;
    logic [1:0]  r_idx;
    logic [2:0]  r_st;
    logic [31:0] r_value, r_mask;
    logic [1:0]  r_word_idx;
    logic        r_last, r_high, r_bad, r_skip;
    logic [62:0] r_time;
    logic        load, is_last;

    assign load    = !i_q_empty && (!r_valid || o_word.ready);
    assign is_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (o_word.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_st       <= i_head.st;
            // value only for binary and four-state, mask only for four-state
            r_value    <= i_head.st[2] ? i_head.value[r_idx] : 32'd0;
            r_mask     <= (i_head.st[2] && i_head.st[1]) ? i_head.mask[r_idx] : 32'd0;
            r_word_idx <= r_idx;
            r_last     <= is_last;
            r_high     <= i_head.all_high;
            r_bad      <= i_head.bad;
            r_time     <= i_head.stamp;
            r_skip     <= i_head.skip;
        end
    end

    assign o_word.valid            = r_valid;
    assign o_word.state_code       = r_st;
    assign o_word.value_word       = r_value;
    assign o_word.mask_word        = r_mask;
    assign o_word.word_index       = r_word_idx;
    assign o_word.last_word        = r_last;
    assign o_word.all_high         = r_high;
    assign o_word.bad_char         = r_bad;
    assign o_word.out_time         = r_time;
    assign o_word.out_skip_compare = r_skip;

endmodule

### rtl/four_state_string_to_vector.sv
// Top level: configuration registers, front end, job queue and back end.
`timescale 1ns / 1ps

// Converts one signal's trace characters (most significant first, signal_width of them)
// into one to four 32-bit value/mask words, low word first. The front end takes one
// character per cycle; for a signal of width n, time and the no-compare flag ride with
// its first character. Each completed signal becomes a job in a two-entry queue, and
// the back end sends one word per cycle while the output is ready, from the queue head
// through a registered output, so a signal yields ceil(n/32) words at most.
// The input stalls only on a final character while both queue entries are taken.
// Registers: 0x0 signal_width (0 acts as 1, above MAX_BITS saturates), 0x4 binary_wide.
// Write registers only while no signal is in flight.
module four_state_string_to_vector #(
    parameter int MAX_BITS = fstv_pkg::MAX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fstv_in_if.sink                        i_char,
    fstv_out_if.source                     o_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fstv_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [7:0]        r_width;
    logic              r_binary_wide;
    logic              wr_en;
    fstv_pkg::t_cfg    cfg;
    fstv_pkg::t_job    push_job, head_job;
    fstv_pkg::t_q_stat q_stat;
    logic              push, pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= 8'd1;
            r_binary_wide <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                fstv_pkg::REG_WIDTH:  r_width       <= pwdata[7:0];
                fstv_pkg::REG_BINARY: r_binary_wide <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fstv_pkg::REG_WIDTH:  prdata = {24'd0, r_width};
            fstv_pkg::REG_BINARY: prdata = {31'd0, r_binary_wide};
            default:              prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_width == 8'd0)
            cfg.width = 8'd1;
        else if (r_width > 8'(MAX_BITS))
            cfg.width = 8'(MAX_BITS);
        else
            cfg.width = r_width;
        cfg.binary_wide = r_binary_wide;
    end

    fstv_front #(.MAX_BITS(MAX_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_cfg    (cfg),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_job    (push_job)
    );

    fstv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    fstv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head_job),
        .i_q_empty (q_stat.empty),
        .o_pop     (pop),
        .o_word    (o_word)
    );

    // word index 3 is always the final word
    a_idx3_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.word_index == 2'd3) |-> o_word.last_word)
        else $error("word index 3 without last_word");

    a_bad_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.bad_char) |->
            (o_word.state_code == fstv_pkg::ST_UNKNOWN && o_word.last_word &&
             o_word.word_index == 2'd0))
        else $error("bad_char on a non-scalar result");

    a_high_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.all_high) |->
            (o_word.state_code == fstv_pkg::ST_BIN_NARROW ||
             o_word.state_code == fstv_pkg::ST_BIN_WIDE))
        else $error("all_high on a non-binary result");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into a full queue");

endmodule

### tb/sv/tb_four_state_string_to_vector.sv
// Self-checking testbench for the four-state trace string to vector converter.
`timescale 1ns / 1ps

module tb_four_state_string_to_vector;
    import fstv_pkg::*;

    localparam int MAX_BITS     = MAX_BITS_DEF;
    localparam int RAND_ITEMS   = 90;
    localparam int QUIET_ITEMS  = 30;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_DIR      = 19;

    typedef enum int {
        K_ZERO, K_BINARY, K_ONES, K_HIGHZ, K_UNKNOWN, K_FOUR, K_NOISE
    } sig_kind_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] value;
        logic [31:0] mask;
        logic [1:0]  idx;
        logic        is_last;
        logic        all_high;
        logic        bad;
        logic [62:0] stamp;
        logic        skip;
    } word_t;

    // one directed signal: characters are head, fill..., tail (MSB first)
    typedef struct packed {
        logic [7:0] width;
        logic       bwide;
        logic [7:0] head;
        logic [7:0] fill;
        logic [7:0] tail;
        logic       typed;
        logic [2:0] st;
        logic       all_high;
        logic       bad;
    } dir_row_t;

    // width, wide, head, fill, tail, typed, state, all_high, bad
    localparam dir_row_t DIR_TAB [NUM_DIR] = '{
        '{8'd1,   1'b0, CH_0,     CH_0, CH_0,     1'b1, ST_ZERO,        1'b0, 1'b0},
        '{8'd1,   1'b0, CH_1,     CH_1, CH_1,     1'b1, ST_ONE,         1'b0, 1'b0},
        '{8'd1,   1'b0, CH_QUERY, CH_0, CH_0,     1'b1, ST_UNKNOWN,     1'b0, 1'b0},
        '{8'd1,   1'b0, CH_X_LO,  CH_0, CH_0,     1'b1, ST_UNKNOWN,     1'b0, 1'b0},
        '{8'd1,   1'b0, CH_X_UP,  CH_0, CH_0,     1'b1, ST_UNKNOWN,     1'b0, 1'b0},
        '{8'd1,   1'b0, CH_U_LO,  CH_0, CH_0,     1'b1, ST_UNKNOWN,     1'b0, 1'b0},
        '{8'd1,   1'b0, CH_U_UP,  CH_0, CH_0,     1'b1, ST_UNKNOWN,     1'b0, 1'b0},
        '{8'd1,   1'b0, CH_Z_LO,  CH_0, CH_0,     1'b1, ST_HIGHZ,       1'b0, 1'b0},
        '{8'd1,   1'b0, CH_Z_UP,  CH_0, CH_0,     1'b1, ST_HIGHZ,       1'b0, 1'b0},
        '{8'd1,   1'b0, 8'h00,    CH_0, CH_0,     1'b1, ST_UNKNOWN,     1'b0, 1'b1},
        '{8'd1,   1'b0, 8'hFF,    CH_0, CH_0,     1'b1, ST_UNKNOWN,     1'b0, 1'b1},
        '{8'd0,   1'b0, CH_1,     CH_1, CH_1,     1'b1, ST_ONE,         1'b0, 1'b0},
        '{8'd2,   1'b0, CH_0,     CH_0, CH_0,     1'b1, ST_ZERO,        1'b0, 1'b0},
        '{8'd8,   1'b0, CH_1,     CH_1, CH_1,     1'b1, ST_BIN_NARROW,  1'b1, 1'b0},
        '{8'd8,   1'b1, CH_0,     CH_1, CH_1,     1'b1, ST_BIN_WIDE,    1'b0, 1'b0},
        '{8'd4,   1'b0, CH_Z_LO,  CH_Z_UP, CH_Z_LO, 1'b1, ST_HIGHZ,     1'b0, 1'b0},
        '{8'd4,   1'b0, CH_U_LO,  CH_U_UP, CH_U_UP, 1'b1, ST_UNKNOWN,   1'b0, 1'b0},
        '{8'd3,   1'b0, CH_0,     CH_Z_LO, CH_Z_LO, 1'b0, ST_ZERO,      1'b0, 1'b0},
        '{8'd33,  1'b0, CH_1,     CH_0, 8'h00,    1'b0, ST_ZERO,        1'b0, 1'b0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        src_valid = 1'b0;
    logic [7:0]  src_char  = '0;
    logic [62:0] src_time  = '0;
    logic        src_skip  = 1'b0;
    logic        sink_ready = 1'b0;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;

    fstv_in_if  ch_in ();
    fstv_out_if ch_out ();

    assign ch_in.valid        = src_valid;
    assign ch_in.char_code    = src_char;
    assign ch_in.sample_time  = src_time;
    assign ch_in.skip_compare = src_skip;
    assign ch_out.ready       = sink_ready;

    four_state_string_to_vector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (ch_in),
        .o_word  (ch_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [7:0]            cfg_width  = 8'd1;
    logic                  cfg_bwide  = 1'b0;
    logic [7:0]            acc_or     = '0;
    logic [7:0]            acc_and    = '1;
    int                    acc_count  = 0;
    logic [STORE_BITS-1:0] val_store  = '0;
    logic [STORE_BITS-1:0] msk_store  = '0;
    logic [62:0]           held_stamp = '0;
    logic                  held_skip  = 1'b0;
    word_t                 pending_words [$];

    int err_count   = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    function automatic int eff_width(input logic [7:0] w);
        if (w == 8'd0) return 1;
        if (int'(w) > MAX_BITS) return MAX_BITS;
        return int'(w);
    endfunction

    function automatic void clear_acc();
        acc_or    = '0;
        acc_and   = '1;
        acc_count = 0;
        val_store = '0;
        msk_store = '0;
    endfunction

    function automatic void push_word(input logic [2:0] st, input logic [31:0] v,
                                      input logic [31:0] m, input int i, input logic lst,
                                      input logic hi, input logic bd);
        word_t w;
        w.st       = st;
        w.value    = v;
        w.mask     = m;
        w.idx      = i[1:0];
        w.is_last  = lst;
        w.all_high = hi;
        w.bad      = bd;
        w.stamp    = held_stamp;
        w.skip     = held_skip;
        pending_words.push_back(w);
    endfunction

    // returns the number of words this character completes
    function automatic int predict_words(input logic [7:0] c, input logic [62:0] t,
                                         input logic s);
        int n;
        int nw;
        int i;
        logic [2:0] st;
        logic hi;
        logic four;
        logic bd;
        n = eff_width(cfg_width);
        if (acc_count == 0) begin
            held_stamp = t;
            held_skip  = s;
        end
        if (n < 2) begin
            bd = 1'b0;
            case (c)
                CH_0: st = ST_ZERO;
                CH_1: st = ST_ONE;
                CH_QUERY, CH_X_LO, CH_X_UP, CH_U_LO, CH_U_UP: st = ST_UNKNOWN;
                CH_Z_LO, CH_Z_UP: st = ST_HIGHZ;
                default: begin
                    st = ST_UNKNOWN;
                    bd = 1'b1;
                end
            endcase
            push_word(st, '0, '0, 0, 1'b1, 1'b0, bd);
            clear_acc();
            return 1;
        end
        acc_or  = acc_or | c;
        acc_and = acc_and & c;
        val_store = {val_store[STORE_BITS-2:0], (c == CH_1 || c == CH_Z_LO || c == CH_Z_UP)};
        msk_store = {msk_store[STORE_BITS-2:0], ((c | 8'h01) != CH_1)};
        acc_count++;
        if (acc_count < n) return 0;

        // classed by the OR of all codes, so e.g. '0' mixed with 'z' reads as high-Z
        nw   = 1;
        hi   = 1'b0;
        four = 1'b0;
        case (acc_or)
            CH_0: st = ST_ZERO;
            CH_1: begin
                hi = (acc_and == CH_1);
                st = cfg_bwide ? ST_BIN_WIDE : ST_BIN_NARROW;
                if (cfg_bwide) nw = (n + 31) / 32;
            end
            CH_Z_LO, CH_Z_UP: st = ST_HIGHZ;
            CH_U_LO, CH_U_UP: st = ST_UNKNOWN;
            default: begin
                four = 1'b1;
                if (n < int'(FOUR_NARROW_LIMIT)) begin
                    st = ST_FOUR_NARROW;
                end else begin
                    st = ST_FOUR_WIDE;
                    nw = (n + 31) / 32;
                end
            end
        endcase
        if (nw > MAX_WORDS) nw = MAX_WORDS;
        for (i = 0; i < nw; i++) begin
            push_word(st, (st >= ST_BIN_NARROW) ? val_store[32*i +: 32] : 32'd0,
                      four ? msk_store[32*i +: 32] : 32'd0, i, (i + 1 == nw), hi, 1'b0);
        end
        clear_acc();
        return nw;
    endfunction

    function automatic logic [62:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic logic [7:0] pick_char(input sig_kind_t kind);
        logic [7:0] state_chars [9];
        state_chars = '{CH_0, CH_1, CH_X_LO, CH_X_UP, CH_U_LO, CH_U_UP,
                        CH_Z_LO, CH_Z_UP, CH_QUERY};
        case (kind)
            K_ZERO:    return CH_0;
            K_BINARY:  return $urandom_range(0, 1) ? CH_1 : CH_0;
            K_ONES:    return CH_1;
            K_HIGHZ:   return $urandom_range(0, 1) ? CH_Z_LO : CH_Z_UP;
            K_UNKNOWN: return $urandom_range(0, 1) ? CH_U_LO : CH_U_UP;
            K_FOUR:    return state_chars[$urandom_range(0, 8)];
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c, input logic [62:0] t, input logic s,
                             output int nw);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            src_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        src_valid <= 1'b1;
        src_char  <= c;
        src_time  <= t;
        src_skip  <= s;
        do @(posedge i_clk); while (!ch_in.ready);
        nw = predict_words(c, t, s);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        logic [31:0] d;
        d      = $urandom;
        d[7:0] = val;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_WIDTH) cfg_width = val;
        else cfg_bwide = val[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending, let every pending word out, then allow the pipe to settle
    task automatic drain_block();
        @(negedge i_clk);
        src_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] w, input logic b);
        drain_block();
        write_reg(REG_WIDTH, w);
        write_reg(REG_BINARY, {7'd0, b});
    endtask

    // result sink with random back-pressure bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        word_t got;
        word_t want;
        if (i_rst_n && ch_out.valid && ch_out.ready) begin
            got.st       = ch_out.state_code;
            got.value    = ch_out.value_word;
            got.mask     = ch_out.mask_word;
            got.idx      = ch_out.word_index;
            got.is_last  = ch_out.last_word;
            got.all_high = ch_out.all_high;
            got.bad      = ch_out.bad_char;
            got.stamp    = ch_out.out_time;
            got.skip     = ch_out.out_skip_compare;
            if (pending_words.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected word st=%0d val=%h msk=%h idx=%0d", $realtime,
                             got.st, got.value, got.mask, got.idx);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: word mismatch", $realtime);
                        $display({"  exp st=%0d val=%h msk=%h idx=%0d last=%b",
                                  " high=%b bad=%b t=%h s=%b"},
                                 want.st, want.value, want.mask, want.idx, want.is_last,
                                 want.all_high, want.bad, want.stamp, want.skip);
                        $display({"  got st=%0d val=%h msk=%h idx=%0d last=%b",
                                  " high=%b bad=%b t=%h s=%b"},
                                 got.st, got.value, got.mask, got.idx, got.is_last,
                                 got.all_high, got.bad, got.stamp, got.skip);
                    end
                end
            end
        end
    end

    // watchdog: no transfer on either channel for too long
    always @(posedge i_clk) begin
        if ((ch_in.valid && ch_in.ready) || (ch_out.valid && ch_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int k;
        int j;
        int n;
        int nw;
        int nsig;
        int sg;
        int pick;
        int rand_chars;
        logic [7:0] c;
        logic [7:0] w;
        dir_row_t row;
        word_t tmp;
        sig_kind_t kind;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed signals
        for (k = 0; k < NUM_DIR; k++) begin
            row = DIR_TAB[k];
            if (row.width != cfg_width || row.bwide != cfg_bwide)
                set_config(row.width, row.bwide);
            n  = eff_width(row.width);
            nw = 0;
            for (j = 0; j < n; j++) begin
                c = (j == 0) ? row.head : ((j == n - 1) ? row.tail : row.fill);
                if (j == 0)
                    send_char(c, k[0] ? {63{1'b1}} : 63'd0, k[0], nw);
                else
                    send_char(c, rand_stamp(), 1'($urandom_range(0, 1)), nw);
            end
            if (row.typed) begin
                for (j = 0; j < nw; j++) begin
                    tmp          = pending_words[pending_words.size() - 1 - j];
                    tmp.st       = row.st;
                    tmp.all_high = row.all_high;
                    tmp.bad      = row.bad;
                    pending_words[pending_words.size() - 1 - j] = tmp;
                end
            end
        end

        // width raised while a signal is half collected
        set_config(8'd4, 1'b0);
        send_char(CH_1, rand_stamp(), 1'b1, nw);
        send_char(CH_0, rand_stamp(), 1'b0, nw);
        drain_block();
        write_reg(REG_WIDTH, 8'd6);
        send_char(CH_X_LO, rand_stamp(), 1'b0, nw);
        send_char(CH_0, rand_stamp(), 1'b0, nw);
        send_char(CH_1, rand_stamp(), 1'b0, nw);
        send_char(CH_1, rand_stamp(), 1'b0, nw);

        // random phases of whole signals, widths kept within the character budget
        rand_chars = 0;
        while (rand_chars < RAND_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)       w = 8'($urandom_range(0, 1));
            else if (pick <= 12) w = 8'($urandom_range(2, 12));
            else if (pick <= 16) w = 8'($urandom_range(28, 40));
            else if (pick <= 18) w = 8'($urandom_range(60, 100));
            else                 w = 8'($urandom_range(128, 255));
            n = eff_width(w);
            if (n > RAND_ITEMS - rand_chars) begin
                w = 8'(RAND_ITEMS - rand_chars);
                n = eff_width(w);
            end
            set_config(w, 1'($urandom_range(0, 1)));
            nsig = (n > 64) ? 1 : $urandom_range(2, 6);
            for (sg = 0; sg < nsig && rand_chars + n <= RAND_ITEMS; sg++) begin
                kind = sig_kind_t'($urandom_range(0, 6));
                for (j = 0; j < n; j++) begin
                    quiet = (rand_chars >= RAND_ITEMS - QUIET_ITEMS);
                    send_char(pick_char(kind), rand_stamp(), 1'($urandom_range(0, 1)), nw);
                    rand_chars++;
                end
            end
        end

        drain_block();
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
